>>> src/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg: shared constants and types for the latency statistics accumulator
// Holds widths, register codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lsa_pkg;
    localparam int DUR_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int MEAN_W    = DUR_W + FRAC_W;
    localparam int CNT_W     = 32;
    localparam int DIV_W     = 16;
    localparam int SQ_W      = 64;
    localparam int TS_W      = 64;
    localparam logic [DIV_W-1:0] DIV_RESET = 16'd100;
    localparam logic [1:0] REG_DIVISOR = 2'd0;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_TOL  = 3'd1;
    localparam logic [ST_W-1:0] ST_MDIV = 3'd2;
    localparam logic [ST_W-1:0] ST_MUL  = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE = 3'd4;
    localparam logic [ST_W-1:0] ST_OUT  = 3'd5;

    typedef struct packed {
        logic                start;
        logic [MEAN_W-1:0]   dividend;
        logic [CNT_W-1:0]    divisor;
    } t_div_req;
endpackage

>>> src/lsa_divider.sv
// ----------------------------------------------------------------------------
// lsa_divider: shared restoring divider
// Unsigned MEAN_W by CNT_W division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsa_divider import lsa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [MEAN_W-1:0] o_quot
);
    localparam int CW = $clog2(MEAN_W + 1);
    logic [MEAN_W-1:0] r_q, n_q;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [CNT_W-1:0]  r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic [CNT_W:0]    w_sh;

    assign w_sh = {r_rem[CNT_W-1:0], r_q[MEAN_W-1]};

    always_comb begin
        n_q = {r_q[MEAN_W-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_req.start && (r_cnt == CW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MEAN_W);
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1))
                    r_busy <= 1'b0;
            end
        end
    end
    assign o_quot = r_q;
endmodule

>>> src/latency_statistics_accumulator.sv
// ----------------------------------------------------------------------------
// latency_statistics_accumulator: running latency statistics
// Min, max, majority mode, Welford mean and sum of squared deviations.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one request per event, tdata = start_time [63:0],
//   end_time [127:64]. Master stream: one result per request with the
//   statistics after it. APB register 0 (address 0): mode tolerance divisor.
//   Sequence: a dropped request (end before start) shows its result in the
//   cycle after acceptance. An accepted request runs the shared serial
//   divider twice (tolerance, mean step), then four 24x24 partial products
//   and the sum update before its result. The first sample skips the mean
//   step, the partial products and the sum update.
//   o_s_tready is low while a request is in work or a result waits.
//   Reset: statistics clear (min to all ones), divisor back to 100.
//   Stall: the result holds on o_m_tdata until i_m_tready; no new request is
//   taken meanwhile.
// ----------------------------------------------------------------------------
module latency_statistics_accumulator import lsa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // start_time[63:0], end_time[127:64]
    input  logic [127:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // accepted[0], duration_clipped[1], sample_count[33:2], min_latency[65:34],
    // max_latency[97:66], mode_latency[129:98], mode_votes[161:130],
    // mean_latency[209:162], sq_dev_sum[273:210], zero fill to 279
    output logic [279:0] o_m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam logic [CNT_W-1:0] CMAX = '1;
    logic [ST_W-1:0]  r_st;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_count, r_votes;
    logic [DUR_W-1:0] r_min, r_max, r_mode, r_d;
    logic [MEAN_W-1:0] r_mean, r_mag, r_magn;
    logic [SQ_W-1:0]  r_sq;
    logic             r_acc, r_clip, r_up;
    logic [1:0]       r_pp;
    logic [2*MEAN_W-1:0] r_prod;
    t_div_req         w_req;
    logic             w_done;
    logic [MEAN_W-1:0] w_quot;
    logic [TS_W-1:0]  w_s, w_e, w_diff;
    logic [MEAN_W-1:0] w_x, w_neu;
    logic [DUR_W:0]   w_low, w_high;
    logic [DUR_W-1:0] w_tol;
    logic [23:0]      w_ma, w_mb;
    logic [47:0]      w_mp;
    logic [2*MEAN_W-1:0] w_pp;
    logic [SQ_W:0]    w_sqs;
    logic [2*MEAN_W-1:0] w_psh;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DIVISOR) ? {16'd0, r_div} : 32'd0;
    assign o_s_tready = (r_st == ST_IDLE);
    assign o_m_tvalid = (r_st == ST_OUT);
    assign w_s = i_s_tdata[63:0];
    assign w_e = i_s_tdata[127:64];
    assign w_diff = w_e - w_s;
    assign w_x = {r_d, {FRAC_W{1'b0}}};
    assign w_tol = w_quot[DUR_W-1:0];
    assign w_low = ({1'b0, r_mode} > {1'b0, w_tol}) ? {1'b0, r_mode - w_tol} : '0;
    assign w_high = {1'b0, r_mode} + {1'b0, w_tol};
    assign w_neu = r_up ? r_mean + w_quot : r_mean - w_quot;
    // one 24x24 multiplier walks the four partial products of the square term
    assign w_ma = r_pp[1] ? r_mag[47:24] : r_mag[23:0];
    assign w_mb = r_pp[0] ? r_magn[47:24] : r_magn[23:0];
    assign w_mp = w_ma * w_mb;
    always_comb begin
        unique case (r_pp)
            2'd0: w_pp = (2*MEAN_W)'(w_mp);
            2'd1: w_pp = (2*MEAN_W)'(w_mp) << 24;
            2'd2: w_pp = (2*MEAN_W)'(w_mp) << 24;
            default: w_pp = (2*MEAN_W)'(w_mp) << 48;
        endcase
    end
    assign w_psh = r_prod >> (2 * FRAC_W);
    assign w_sqs = {1'b0, r_sq} + {1'b0, w_psh[SQ_W-1:0]};

    always_comb begin
        w_req.start = 1'b0;
        w_req.dividend = '0;
        w_req.divisor = '0;
        if (r_st == ST_IDLE && i_s_tvalid && w_e >= w_s) begin
            w_req.start = 1'b1;
            w_req.dividend = MEAN_W'(w_diff[TS_W-1:DUR_W] != 0 ? {DUR_W{1'b1}}
                                                                 : w_diff[DUR_W-1:0]);
            w_req.divisor = CNT_W'((r_div == 0) ? DIV_W'(1) : r_div);
        end else if (r_st == ST_TOL && w_done && r_count != CNT_W'(1)) begin
            w_req.start = 1'b1;
            w_req.dividend = r_up ? w_x - r_mean : r_mean - w_x;
            w_req.divisor = r_count;
        end
    end

    lsa_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .o_done(w_done), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_div <= DIV_RESET;
            r_count <= '0; r_min <= '1; r_max <= '0; r_mode <= '0;
            r_votes <= '0; r_mean <= '0; r_sq <= '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_DIVISOR)
                r_div <= pwdata[DIV_W-1:0];
            unique case (r_st)
                ST_IDLE: if (i_s_tvalid) begin
                    r_acc <= w_e >= w_s;
                    r_clip <= (w_e >= w_s) && (w_diff[TS_W-1:DUR_W] != 0);
                    r_st <= (w_e >= w_s) ? ST_TOL : ST_OUT;
                    if (w_e >= w_s) begin
                        r_d <= (w_diff[TS_W-1:DUR_W] != 0) ? '1 : w_diff[DUR_W-1:0];
                        if (r_count != CMAX) r_count <= r_count + 1'b1;
                    end
                end
                ST_TOL: begin
                    r_up <= w_x >= r_mean;
                    if (w_done) begin
                        if (r_d < r_min) r_min <= r_d;
                        if (r_d > r_max) r_max <= r_d;
                        if ({1'b0, r_d} >= w_low && {1'b0, r_d} <= w_high) begin
                            if (r_votes != CMAX) r_votes <= r_votes + 1'b1;
                        end else if (r_votes == 0) r_mode <= r_d;
                        else r_votes <= r_votes - 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            r_mean <= w_x; r_sq <= '0; r_st <= ST_OUT;
                        end else begin
                            r_mag <= r_up ? w_x - r_mean : r_mean - w_x;
                            r_st <= ST_MDIV;
                        end
                    end
                end
                ST_MDIV: if (w_done) begin
                    r_mean <= w_neu;
                    r_magn <= r_up ? w_x - w_neu : w_neu - w_x;
                    r_prod <= '0; r_pp <= '0;
                    r_st <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod <= r_prod + w_pp;
                    r_pp <= r_pp + 1'b1;
                    if (r_pp == 2'd3) r_st <= ST_DONE;
                end
                ST_DONE: begin
                    r_sq <= (w_psh[2*MEAN_W-1:SQ_W] != 0 || w_sqs[SQ_W]) ? '1
                                                                       : w_sqs[SQ_W-1:0];
                    r_st <= ST_OUT;
                end
                ST_OUT: if (i_m_tready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tdata = {6'd0, r_sq, r_mean, r_votes, r_mode, r_max, r_min, r_count,
                        r_clip, r_acc};

`ifndef SYNTH
    a_noaccept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata)) else $error("result changed");
    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_count != 0 |-> r_min <= r_max) else $error("min above max");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !r_acc |-> !r_clip) else $error("clip on dropped");
`endif
endmodule

>>> sim/tb_latency_statistics_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latency_statistics_accumulator: self-checking bench for the accumulator
// Drives timestamp requests, checks each result against a running model of
// the min, max, majority mode, Welford mean and squared deviation sum.
// ----------------------------------------------------------------------------
module tb_latency_statistics_accumulator;
    import lsa_pkg::*;

    typedef struct {
        logic              acc;
        logic              clip;
        logic [CNT_W-1:0]  cnt;
        logic [DUR_W-1:0]  lo;
        logic [DUR_W-1:0]  hi;
        logic [DUR_W-1:0]  mode;
        logic [CNT_W-1:0]  votes;
        logic [MEAN_W-1:0] mean;
        logic [SQ_W-1:0]   sq;
    } t_stats;

    typedef struct {
        logic [TS_W-1:0]  t0;
        logic [TS_W-1:0]  t1;
        bit               known;
        logic             acc;
        logic             clip;
        logic [CNT_W-1:0] cnt;
        logic [DUR_W-1:0] lo;
        logic [DUR_W-1:0] hi;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [279:0] o_m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    latency_statistics_accumulator DUT (.*);

    always #1 i_clk = ~i_clk;

    logic [DIV_W-1:0]  tol_div;
    logic [CNT_W-1:0]  n_samp;
    logic [DUR_W-1:0]  lat_min, lat_max, mode_cand;
    logic [CNT_W-1:0]  mode_cnt;
    logic [63:0]       mean_acc;
    logic [SQ_W-1:0]   sq_acc;
    t_stats            pending_stats[$];
    t_stats            last_stats;
    int                errors = 0;
    bit                idle_en = 1'b1;

    task automatic stat_update(input logic [63:0] t0, input logic [63:0] t1,
                               output t_stats r);
        logic [63:0]  d64, x, mag_old, mag_new, q, neu, p;
        logic [DUR_W-1:0] d, tol;
        logic [DUR_W-1:0] lowb;
        logic [DUR_W:0]   highb;
        logic [DIV_W-1:0] dv;
        logic [127:0] prod;
        logic [64:0]  s;
        bit up;
        r.acc = 1'b0;
        r.clip = 1'b0;
        if (t1 >= t0) begin
            r.acc = 1'b1;
            d64 = t1 - t0;
            if (d64 > 64'hFFFF_FFFF) begin
                d = '1;
                r.clip = 1'b1;
            end else begin
                d = d64[31:0];
            end
            if (n_samp != '1) n_samp = n_samp + 1;
            if (d < lat_min) lat_min = d;
            if (d > lat_max) lat_max = d;
            dv = (tol_div == 0) ? 16'd1 : tol_div;
            tol = d / dv;
            lowb = (mode_cand > tol) ? mode_cand - tol : '0;
            highb = {1'b0, mode_cand} + tol;
            if (d >= lowb && {1'b0, d} <= highb) begin
                if (mode_cnt != '1) mode_cnt = mode_cnt + 1;
            end else if (mode_cnt == 0) begin
                mode_cand = d;
            end else begin
                mode_cnt = mode_cnt - 1;
            end
            x = {16'd0, d, 16'd0};
            if (n_samp == 1) begin
                mean_acc = x;
                sq_acc = '0;
            end else begin
                up = (x >= mean_acc);
                mag_old = up ? x - mean_acc : mean_acc - x;
                q = mag_old / {32'd0, n_samp};
                neu = up ? mean_acc + q : mean_acc - q;
                mag_new = up ? x - neu : neu - x;
                mean_acc = neu;
                prod = ({64'd0, mag_old} * {64'd0, mag_new}) >> 32;
                p = (prod[127:64] != 0) ? '1 : prod[63:0];
                s = {1'b0, sq_acc} + {1'b0, p};
                sq_acc = s[64] ? '1 : s[63:0];
            end
        end
        r.cnt = n_samp;
        r.lo = lat_min;
        r.hi = lat_max;
        r.mode = mode_cand;
        r.votes = mode_cnt;
        r.mean = mean_acc[47:0];
        r.sq = sq_acc;
    endtask

    function automatic void field_check(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h got %h", name, e, a);
        end
    endfunction

    always @(posedge i_clk) begin
        t_stats r, e;
        if (!i_rst_n) begin
            tol_div <= DIV_RESET;
            n_samp = '0;
            lat_min = '1;
            lat_max = '0;
            mode_cand = '0;
            mode_cnt = '0;
            mean_acc = '0;
            sq_acc = '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_DIVISOR)
                tol_div <= pwdata[DIV_W-1:0];
            if (i_s_tvalid && o_s_tready) begin
                stat_update(i_s_tdata[63:0], i_s_tdata[127:64], e);
                pending_stats.push_back(e);
            end
            if (o_m_tvalid && i_m_tready) begin
                r.acc   = o_m_tdata[0];
                r.clip  = o_m_tdata[1];
                r.cnt   = o_m_tdata[33:2];
                r.lo    = o_m_tdata[65:34];
                r.hi    = o_m_tdata[97:66];
                r.mode  = o_m_tdata[129:98];
                r.votes = o_m_tdata[161:130];
                r.mean  = o_m_tdata[209:162];
                r.sq    = o_m_tdata[273:210];
                last_stats = r;
                if (pending_stats.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result");
                end else begin
                    e = pending_stats.pop_front();
                    field_check("accepted", e.acc, r.acc);
                    field_check("duration_clipped", e.clip, r.clip);
                    field_check("sample_count", e.cnt, r.cnt);
                    field_check("min_latency", e.lo, r.lo);
                    field_check("max_latency", e.hi, r.hi);
                    field_check("mode_latency", e.mode, r.mode);
                    field_check("mode_votes", e.votes, r.votes);
                    field_check("mean_latency", e.mean, r.mean);
                    field_check("sq_dev_sum", e.sq, r.sq);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_m_tready <= idle_en ? ($urandom_range(0, 99) >= 12) : 1'b1;

    task automatic send_request(input logic [63:0] t0, input logic [63:0] t1);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 99) < 12)
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {t1, t0};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_stats.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_divisor(input logic [DIV_W-1:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_DIVISOR;
        pwdata <= {16'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_request(input logic [DUR_W-1:0] center);
        logic [63:0] t0, t1, d;
        int k;
        k = $urandom_range(0, 99);
        t0 = {$urandom, $urandom} >> $urandom_range(0, 40);
        if (k < 10) begin
            t1 = t0 - 64'($urandom_range(1, 1000));
        end else if (k < 18) begin
            t0 = {$urandom, $urandom};
            t1 = {$urandom, $urandom};
        end else if (k < 24) begin
            t1 = t0 + 64'h1_0000_0000 + 64'($urandom);
        end else if (k < 65) begin
            d = 64'(center) + 64'($urandom_range(0, 40)) - 64'd20;
            t1 = t0 + d;
        end else begin
            t1 = t0 + 64'($urandom >> $urandom_range(0, 31));
        end
        send_request(t0, t1);
    endtask

    t_row steps[] = '{
        '{64'd5, 64'd3, 1, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0},
        '{64'd0, 64'd0, 1, 1'b1, 1'b0, 32'd1, 32'd0, 32'd0},
        '{64'd0, '1, 1, 1'b1, 1'b1, 32'd2, 32'd0, 32'hFFFF_FFFF},
        '{'1, '1, 1, 1'b1, 1'b0, 32'd3, 32'd0, 32'hFFFF_FFFF},
        '{'1, 64'd0, 1, 1'b0, 1'b0, 32'd3, 32'd0, 32'hFFFF_FFFF},
        '{64'd0, 64'd1000, 0, 0, 0, 0, 0, 0},
        '{64'd100, 64'd1100, 0, 0, 0, 0, 0, 0},
        '{64'd50, 64'd1040, 0, 0, 0, 0, 0, 0},
        '{64'd10, 64'd5, 1, 1'b0, 1'b0, 32'd6, 32'd0, 32'hFFFF_FFFF},
        '{64'h1_0000_0000, 64'h1_FFFF_FFFF, 1, 1'b1, 1'b0, 32'd7, 32'd0, 32'hFFFF_FFFF},
        '{64'h1_0000_0000, 64'h2_0000_0000, 1, 1'b1, 1'b1, 32'd8, 32'd0, 32'hFFFF_FFFF},
        '{64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0, 0, 0, 0},
        '{64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0, 0},
        '{64'd7, 64'd8, 0, 0, 0, 0, 0, 0},
        '{64'd7, 64'd7, 0, 0, 0, 0, 0, 0},
        '{64'd0, 64'd3, 0, 0, 0, 0, 0, 0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_D555_5555, 0, 0, 0, 0, 0, 0},
        '{64'h5555_5555_5555_5555, 64'h5555_5555_D555_5555, 0, 0, 0, 0, 0, 0}
    };

    logic [DIV_W-1:0] div_plan[] = '{16'd100, 16'd1, 16'd0, 16'hFFFF, 16'd7, 16'd3};

    initial begin
        logic [DUR_W-1:0] center;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (steps[i]) begin
            send_request(steps[i].t0, steps[i].t1);
            while (pending_stats.size() != 0) @(negedge i_clk);
            if (steps[i].known) begin
                field_check("accepted", steps[i].acc, last_stats.acc);
                field_check("duration_clipped", steps[i].clip, last_stats.clip);
                field_check("sample_count", steps[i].cnt, last_stats.cnt);
                field_check("min_latency", steps[i].lo, last_stats.lo);
                field_check("max_latency", steps[i].hi, last_stats.hi);
            end
        end
        write_divisor(16'd2);
        send_request(64'd0, 64'd20);
        send_request(64'd0, 64'd2000);
        send_request(64'd0, 64'd0);
        foreach (div_plan[p]) begin
            write_divisor(div_plan[p] == 16'd7 ? 16'($urandom) : div_plan[p]);
            idle_en = (p != 3);
            center = $urandom >> $urandom_range(0, 28);
            repeat (140) begin
                if ($urandom_range(0, 29) == 0) center = $urandom >> $urandom_range(0, 28);
                random_request(center);
            end
        end
        idle_en = 1'b1;
        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("[latency_statistics_accumulator] OK");
        else
            $display("[latency_statistics_accumulator] ERROR");
        $finish;
    end

    initial begin
        #3000000;
        $display("[latency_statistics_accumulator] ERROR");
        $finish;
    end
endmodule

>>> latency_statistics_accumulator.f
src/lsa_pkg.sv
src/lsa_divider.sv
src/latency_statistics_accumulator.sv
sim/tb_latency_statistics_accumulator.sv
